// ===== hw/rtl/kmds_pkg.sv =====
// Package: shared constants and types of the key matrix debounce scanner.
package kmds_pkg;

	localparam int ROW_FIELD_W  = 3;
	localparam int COL_FIELD_W  = 16;
	localparam int QCOL_W       = 4;
	localparam int TIME_W       = 16;
	localparam int CFG_W        = 8;

	localparam int NUM_ROWS_DEF = 8;
	localparam int NUM_COLS_DEF = 16;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 8'd5;

	typedef struct packed {
		logic committed;
		logic settling;
	} status_t;

endpackage

// ===== hw/rtl/key_matrix_debounce_scanner_top.sv =====
// Top level of the key matrix scanner with global debounce.
//
// Usage: each input transaction carries one row sample (scan_row, column_bits),
// the sample time now_ms, an end_of_scan flag and a query (query_row, query_col).
// Each input transaction yields exactly one output transaction: the debounced
// bits of query_row and the key at query_col after this sample, plus the
// committed and settling flags.
// The transaction is captured in the input stage, and the matrix update and query are
// computed in one pass into the output register.
// Throughput is one transaction per cycle while out_ready is high, limited by the
// single-pass update of the state registers.
// When out_ready is low the output register holds its result; the input stage
// still takes one more transaction, then in_ready drops until the result is taken.
// debounce_ms is written over the cfg channel (always ready); writing it only while the block idles is up to the user.
// Reset clears both matrices, the debounce state and sets debounce_ms to 5.
module key_matrix_debounce_scanner_top #(
	parameter int NUM_ROWS = kmds_pkg::NUM_ROWS_DEF,
	parameter int NUM_COLS = kmds_pkg::NUM_COLS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [kmds_pkg::ROW_FIELD_W-1:0]   scan_row,
	input  logic [kmds_pkg::COL_FIELD_W-1:0]   column_bits,
	input  logic [kmds_pkg::TIME_W-1:0]        now_ms,
	input  logic                               end_of_scan,
	input  logic [kmds_pkg::ROW_FIELD_W-1:0]   query_row,
	input  logic [kmds_pkg::QCOL_W-1:0]        query_col,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [kmds_pkg::COL_FIELD_W-1:0]   stable_row_bits,
	output logic                               key_on,
	output logic                               committed,
	output logic                               settling,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kmds_pkg::CFG_W-1:0]         cfg_data
);
	import kmds_pkg::*;

	localparam int ROW_CNT = (NUM_ROWS < (1 << ROW_FIELD_W)) ? NUM_ROWS : (1 << ROW_FIELD_W);
	localparam int COL_W   = (NUM_COLS < COL_FIELD_W) ? NUM_COLS : COL_FIELD_W;

	logic [CFG_W-1:0]       debounce_q;

	logic                   valid_s1;
	logic [ROW_FIELD_W-1:0] scan_row_s1;
	logic [COL_FIELD_W-1:0] column_bits_s1;
	logic [TIME_W-1:0]      now_ms_s1;
	logic                   end_of_scan_s1;
	logic [ROW_FIELD_W-1:0] query_row_s1;
	logic [QCOL_W-1:0]      query_col_s1;

	logic                   out_valid_q;
	logic [COL_FIELD_W-1:0] row_bits_q;
	logic                   key_on_q;
	status_t                status_q;

	logic                   advance;
	logic [COL_W-1:0]       stable_next [ROW_CNT];
	status_t                status;
	logic [COL_FIELD_W-1:0] row_bits;
	logic                   key_bit;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_valid) begin
			debounce_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			scan_row_s1    <= scan_row;
			column_bits_s1 <= column_bits;
			now_ms_s1      <= now_ms;
			end_of_scan_s1 <= end_of_scan;
			query_row_s1   <= query_row;
			query_col_s1   <= query_col;
		end
	end

	kmds_matrix #(
		.NUM_ROWS(NUM_ROWS),
		.NUM_COLS(NUM_COLS)
	) u_matrix (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.scan_row    (scan_row_s1),
		.column_bits (column_bits_s1),
		.now_ms      (now_ms_s1),
		.end_of_scan (end_of_scan_s1),
		.debounce_ms (debounce_q),
		.stable_next (stable_next),
		.status      (status)
	);

	kmds_query #(
		.NUM_ROWS(NUM_ROWS),
		.NUM_COLS(NUM_COLS)
	) u_query (
		.stable_rows (stable_next),
		.query_row   (query_row_s1),
		.query_col   (query_col_s1),
		.row_bits    (row_bits),
		.key_on      (key_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			row_bits_q <= row_bits;
			key_on_q   <= key_bit;
			status_q   <= status;
		end
	end

	assign out_valid       = out_valid_q;
	assign stable_row_bits = row_bits_q;
	assign key_on          = key_on_q;
	assign committed       = status_q.committed;
	assign settling        = status_q.settling;

endmodule

// ===== hw/rtl/kmds_matrix.sv =====
// Pending and stable matrices, debounce timer state and commit logic.
module kmds_matrix #(
	parameter int NUM_ROWS = 8,
	parameter int NUM_COLS = 16,
	localparam int ROW_CNT = (NUM_ROWS < (1 << kmds_pkg::ROW_FIELD_W)) ? NUM_ROWS
		: (1 << kmds_pkg::ROW_FIELD_W),
	localparam int COL_W = (NUM_COLS < kmds_pkg::COL_FIELD_W) ? NUM_COLS
		: kmds_pkg::COL_FIELD_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [kmds_pkg::ROW_FIELD_W-1:0]   scan_row,
	input  logic [kmds_pkg::COL_FIELD_W-1:0]   column_bits,
	input  logic [kmds_pkg::TIME_W-1:0]        now_ms,
	input  logic                               end_of_scan,
	input  logic [kmds_pkg::CFG_W-1:0]         debounce_ms,
	output logic [COL_W-1:0]                   stable_next [ROW_CNT],
	output kmds_pkg::status_t                  status
);
	import kmds_pkg::*;

	logic [COL_W-1:0]  pend_q   [ROW_CNT];
	logic [COL_W-1:0]  stable_q [ROW_CNT];
	logic [COL_W-1:0]  pend_next [ROW_CNT];
	logic              armed_q;
	logic [TIME_W-1:0] stamp_q;

	logic [COL_W-1:0]  bits;
	logic [ROW_CNT-1:0] sel;
	logic [ROW_CNT-1:0] diff;
	logic              changed;
	logic              armed_mid;
	logic [TIME_W-1:0] stamp_mid;
	logic [TIME_W-1:0] elapsed;
	logic              commit;
	logic              armed_next;

	assign bits = column_bits[COL_W-1:0];

	always_comb begin
		for (int i = 0; i < ROW_CNT; i++) begin
			sel[i]  = (scan_row == ROW_FIELD_W'(i));
			diff[i] = (pend_q[i] != bits);
			pend_next[i] = sel[i] ? bits : pend_q[i];
		end
	end

	assign changed    = |(sel & diff);
	assign armed_mid  = changed | armed_q;
	assign stamp_mid  = changed ? now_ms : stamp_q;
	assign elapsed    = now_ms - stamp_mid;
	assign commit     = end_of_scan && armed_mid && (elapsed > {8'd0, debounce_ms});
	assign armed_next = armed_mid & ~commit;

	always_comb begin
		for (int i = 0; i < ROW_CNT; i++) begin
			stable_next[i] = commit ? pend_next[i] : stable_q[i];
		end
	end

	assign status.committed = commit;
	assign status.settling  = armed_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			stamp_q <= '0;
			for (int i = 0; i < ROW_CNT; i++) begin
				pend_q[i]   <= '0;
				stable_q[i] <= '0;
			end
		end else if (step) begin
			armed_q <= armed_next;
			stamp_q <= stamp_mid;
			for (int i = 0; i < ROW_CNT; i++) begin
				pend_q[i]   <= pend_next[i];
				stable_q[i] <= stable_next[i];
			end
		end
	end

endmodule

// ===== hw/rtl/kmds_query.sv =====
// Stable row and key lookup for one query.
module kmds_query #(
	parameter int NUM_ROWS = 8,
	parameter int NUM_COLS = 16,
	localparam int ROW_CNT = (NUM_ROWS < (1 << kmds_pkg::ROW_FIELD_W)) ? NUM_ROWS
		: (1 << kmds_pkg::ROW_FIELD_W),
	localparam int COL_W = (NUM_COLS < kmds_pkg::COL_FIELD_W) ? NUM_COLS
		: kmds_pkg::COL_FIELD_W
) (
	input  logic [COL_W-1:0]                 stable_rows [ROW_CNT],
	input  logic [kmds_pkg::ROW_FIELD_W-1:0] query_row,
	input  logic [kmds_pkg::QCOL_W-1:0]      query_col,
	output logic [kmds_pkg::COL_FIELD_W-1:0] row_bits,
	output logic                             key_on
);
	import kmds_pkg::*;

	logic [COL_W-1:0] picked;

	always_comb begin
		picked = '0;
		for (int i = 0; i < ROW_CNT; i++) begin
			if (query_row == ROW_FIELD_W'(i)) begin
				picked = picked | stable_rows[i];
			end
		end
	end

	// columns beyond COL_W read as zero, so the key bit needs no range check
	assign row_bits = COL_FIELD_W'(picked);
	assign key_on   = row_bits[query_col];

endmodule
